// File: src/particle_contact_impulse_defines.svh
// assertion macros shared by the contact impulse rtl
`ifndef PARTICLE_CONTACT_IMPULSE_DEFINES_SVH
`define PARTICLE_CONTACT_IMPULSE_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define PCIMP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("contact impulse check failed");

// next-cycle implication, disabled while reset is held
`define PCIMP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("contact impulse check failed");

`endif

// File: src/pcimp_pkg.sv
`timescale 1ns / 1ps

package pcimp_pkg;

    localparam int unsigned NORM_BITS = 30;
    localparam int unsigned VEL_W     = 32;
    localparam int unsigned MASS_W    = 24;
    localparam int unsigned RES_W     = 17;
    localparam logic [RES_W-1:0] RES_ONE = 17'h10000;
    localparam int unsigned LEN2_W    = 64;
    localparam int unsigned DIV_D_W   = 32;
    localparam int unsigned DIV_Q_W   = 31;
    localparam int unsigned DIV_LANES = 5;
    localparam int unsigned KDIV_W    = 56;
    localparam int unsigned MSUM_W    = 25;

    typedef enum logic [1:0] {
        OUT_APPLIED   = 2'd0,
        OUT_SKIPPED   = 2'd1,
        OUT_INVALID   = 2'd2,
        OUT_SATURATED = 2'd3
    } t_outcome;

    // carried alongside the square root
    typedef struct packed {
        logic [2:0][31:0] pm;
        logic [2:0]       pneg;
        logic [2:0][31:0] v1;
        logic [2:0][31:0] v2;
        logic [1:0][55:0] kdiv;
        logic [24:0]      msum;
        logic             invalid;
    } t_sqrt_side;

    // carried alongside the dividers
    typedef struct packed {
        logic [2:0][31:0] v1;
        logic [2:0][31:0] v2;
        logic [2:0]       pneg;
        logic             invalid;
    } t_div_side;

endpackage

// File: src/pcimp_if.sv
`timescale 1ns / 1ps

interface pcimp_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [pcimp_pkg::VEL_W-1:0]     rel_pos_x;
    logic signed [pcimp_pkg::VEL_W-1:0]     rel_pos_y;
    logic signed [pcimp_pkg::VEL_W-1:0]     rel_pos_z;
    logic signed [pcimp_pkg::VEL_W-1:0]     first_vel_x;
    logic signed [pcimp_pkg::VEL_W-1:0]     first_vel_y;
    logic signed [pcimp_pkg::VEL_W-1:0]     first_vel_z;
    logic signed [pcimp_pkg::VEL_W-1:0]     second_vel_x;
    logic signed [pcimp_pkg::VEL_W-1:0]     second_vel_y;
    logic signed [pcimp_pkg::VEL_W-1:0]     second_vel_z;
    logic [pcimp_pkg::MASS_W-1:0]           first_mass;
    logic [pcimp_pkg::MASS_W-1:0]           second_mass;

    modport source (
        output valid, rel_pos_x, rel_pos_y, rel_pos_z,
        output first_vel_x, first_vel_y, first_vel_z,
        output second_vel_x, second_vel_y, second_vel_z,
        output first_mass, second_mass,
        input  ready
    );
    modport sink (
        input  valid, rel_pos_x, rel_pos_y, rel_pos_z,
        input  first_vel_x, first_vel_y, first_vel_z,
        input  second_vel_x, second_vel_y, second_vel_z,
        input  first_mass, second_mass,
        output ready
    );
endinterface

interface pcimp_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [pcimp_pkg::VEL_W-1:0]     new_first_vel_x;
    logic signed [pcimp_pkg::VEL_W-1:0]     new_first_vel_y;
    logic signed [pcimp_pkg::VEL_W-1:0]     new_first_vel_z;
    logic signed [pcimp_pkg::VEL_W-1:0]     new_second_vel_x;
    logic signed [pcimp_pkg::VEL_W-1:0]     new_second_vel_y;
    logic signed [pcimp_pkg::VEL_W-1:0]     new_second_vel_z;
    pcimp_pkg::t_outcome                    outcome;

    modport source (
        output valid, new_first_vel_x, new_first_vel_y, new_first_vel_z,
        output new_second_vel_x, new_second_vel_y, new_second_vel_z, outcome,
        input  ready
    );
    modport sink (
        input  valid, new_first_vel_x, new_first_vel_y, new_first_vel_z,
        input  new_second_vel_x, new_second_vel_y, new_second_vel_z, outcome,
        output ready
    );
endinterface

// File: src/pcimp_prep.sv
`timescale 1ns / 1ps

module pcimp_prep (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [2:0][31:0]        i_pos,
    input  logic [2:0][31:0]        i_v1,
    input  logic [2:0][31:0]        i_v2,
    input  logic [23:0]             i_m1,
    input  logic [23:0]             i_m2,
    input  logic [16:0]             i_restitution,
    output logic                    o_valid,
    output logic [63:0]             o_len2,
    output pcimp_pkg::t_sqrt_side   o_side
);

    logic [3:0] r_valid;

    // stage 1: magnitudes, input checks and restitution clamp
    logic [2:0][31:0] n_pm;
    logic [2:0]       n_pneg;
    logic             n_invalid;
    logic [16:0]      n_e;
    logic [2:0][31:0] r_s1_pm, r_s1_v1, r_s1_v2;
    logic [2:0]       r_s1_pneg;
    logic [23:0]      r_s1_m1, r_s1_m2;
    logic [16:0]      r_s1_e;
    logic             r_s1_invalid;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_pneg[i] = i_pos[i][31];
            n_pm[i]   = i_pos[i][31] ? 32'(-i_pos[i]) : i_pos[i];
        end
        n_invalid = (i_m1 == '0) || (i_m2 == '0) || (i_pos == '0);
        n_e = (i_restitution > pcimp_pkg::RES_ONE) ? pcimp_pkg::RES_ONE : i_restitution;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_pm      <= n_pm;
            r_s1_pneg    <= n_pneg;
            r_s1_v1      <= i_v1;
            r_s1_v2      <= i_v2;
            r_s1_m1      <= i_m1;
            r_s1_m2      <= i_m2;
            r_s1_e       <= n_e;
            r_s1_invalid <= n_invalid;
        end
    end

    // stage 2: prescale so the largest component reaches bit 30, mass-share dividends
    logic [31:0]           or_all;
    logic [4:0]            sh;
    logic [17:0]           f;
    logic [24:0]           msum;
    logic [41:0]           fm1, fm2;
    pcimp_pkg::t_sqrt_side n_s2_side;
    pcimp_pkg::t_sqrt_side r_s2_side;

    always_comb begin
        or_all = r_s1_pm[0] | r_s1_pm[1] | r_s1_pm[2];
        sh = '0;
        for (int b = 0; b < 30; b++) begin
            if (or_all[b]) begin
                sh = 5'(30 - b);
            end
        end
        if (or_all[31:30] != 2'b00) begin
            sh = '0;
        end
        f    = 18'(pcimp_pkg::RES_ONE) + 18'(r_s1_e);
        msum = 25'(r_s1_m1) + 25'(r_s1_m2);
        fm1  = 42'(f) * 42'(r_s1_m1);
        fm2  = 42'(f) * 42'(r_s1_m2);
        for (int i = 0; i < 3; i++) begin
            n_s2_side.pm[i] = r_s1_pm[i] << sh;
        end
        n_s2_side.pneg    = r_s1_pneg;
        n_s2_side.v1      = r_s1_v1;
        n_s2_side.v2      = r_s1_v2;
        // first particle's share uses the other mass
        n_s2_side.kdiv[0] = 56'({fm2, 14'b0}) + 56'(msum[24:1]);
        n_s2_side.kdiv[1] = 56'({fm1, 14'b0}) + 56'(msum[24:1]);
        n_s2_side.msum    = msum;
        n_s2_side.invalid = r_s1_invalid;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_side <= n_s2_side;
        end
    end

    // stage 3: squares
    logic [2:0][63:0]      r_s3_sq;
    pcimp_pkg::t_sqrt_side r_s3_side;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_s3_sq[i] <= 64'(r_s2_side.pm[i]) * 64'(r_s2_side.pm[i]);
            end
            r_s3_side <= r_s2_side;
        end
    end

    // stage 4: squared length
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_len2 <= r_s3_sq[0] + r_s3_sq[1] + r_s3_sq[2];
            o_side <= r_s3_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[2:0], i_valid};
        end
    end

    assign o_valid = r_valid[3];

endmodule

// File: src/pcimp_sqrt.sv
`timescale 1ns / 1ps

// integer square root, two radicand bits per stage
module pcimp_sqrt #(
    parameter  int unsigned X_W  = pcimp_pkg::LEN2_W,
    parameter  int unsigned SB_W = 1,
    localparam int unsigned R_W  = X_W / 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [X_W-1:0]  i_x,
    input  logic [SB_W-1:0] i_sb,
    output logic            o_valid,
    output logic [R_W-1:0]  o_root,
    output logic [SB_W-1:0] o_sb
);

    localparam int unsigned REM_W = R_W + 2;
    localparam int unsigned T_W   = R_W + 4;

    logic            r_v    [0:R_W-1];
    logic [REM_W-1:0] r_rem [0:R_W-1];
    logic [R_W-1:0]  r_root [0:R_W-1];
    logic [X_W-1:0]  r_x    [0:R_W-2];
    logic [SB_W-1:0] r_sb   [0:R_W-1];

    for (genvar s = 0; s < R_W; s++) begin : g_stage
        logic             p_v;
        logic [REM_W-1:0] p_rem;
        logic [R_W-1:0]   p_root;
        logic [X_W-1:0]   p_x;
        logic [SB_W-1:0]  p_sb;
        logic [T_W-1:0]   trial;
        logic [T_W-1:0]   tsub;
        logic             take;

        if (s == 0) begin : g_first
            assign p_v    = i_valid;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_x    = i_x;
            assign p_sb   = i_sb;
        end else begin : g_next
            assign p_v    = r_v[s-1];
            assign p_rem  = r_rem[s-1];
            assign p_root = r_root[s-1];
            assign p_x    = r_x[s-1];
            assign p_sb   = r_sb[s-1];
        end

        always_comb begin
            trial = {p_rem, p_x[X_W-1 -: 2]};
            tsub  = T_W'({p_root, 2'b01});
            take  = (trial >= tsub);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= take ? REM_W'(trial - tsub) : REM_W'(trial);
                r_root[s] <= {p_root[R_W-2:0], take};
                r_sb[s]   <= p_sb;
            end
        end

        if (s < R_W - 1) begin : g_xreg
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[s] <= {p_x[X_W-3:0], 2'b00};
                end
            end
        end
    end

    assign o_valid = r_v[R_W-1];
    assign o_root  = r_root[R_W-1];
    assign o_sb    = r_sb[R_W-1];

endmodule

// File: src/pcimp_div.sv
`timescale 1ns / 1ps

// restoring divider, one quotient bit per stage, several lanes in lockstep
// the top D_W bits of each dividend must be below its divisor
module pcimp_div #(
    parameter  int unsigned LANES = pcimp_pkg::DIV_LANES,
    parameter  int unsigned D_W   = pcimp_pkg::DIV_D_W,
    parameter  int unsigned Q_W   = pcimp_pkg::DIV_Q_W,
    parameter  int unsigned SB_W  = 1,
    localparam int unsigned N_W   = D_W + Q_W
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [LANES-1:0][N_W-1:0]  i_dividend,
    input  logic [LANES-1:0][D_W-1:0]  i_divisor,
    input  logic [SB_W-1:0]            i_sb,
    output logic                       o_valid,
    output logic [LANES-1:0][Q_W-1:0]  o_quot,
    output logic [SB_W-1:0]            o_sb
);

    logic                      r_v   [0:Q_W-1];
    logic [LANES-1:0][D_W-1:0] r_rem [0:Q_W-1];
    logic [LANES-1:0][Q_W-1:0] r_lq  [0:Q_W-1];
    logic [LANES-1:0][D_W-1:0] r_dvs [0:Q_W-2];
    logic [SB_W-1:0]           r_sb  [0:Q_W-1];

    for (genvar s = 0; s < Q_W; s++) begin : g_stage
        logic                      p_v;
        logic [LANES-1:0][D_W-1:0] p_rem;
        logic [LANES-1:0][Q_W-1:0] p_lq;
        logic [LANES-1:0][D_W-1:0] p_dvs;
        logic [SB_W-1:0]           p_sb;
        logic [LANES-1:0][D_W-1:0] n_rem;
        logic [LANES-1:0][Q_W-1:0] n_lq;
        logic [D_W:0]              trial;
        logic                      take;

        if (s == 0) begin : g_first
            assign p_v   = i_valid;
            assign p_dvs = i_divisor;
            assign p_sb  = i_sb;
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    p_rem[l] = i_dividend[l][N_W-1:Q_W];
                    p_lq[l]  = i_dividend[l][Q_W-1:0];
                end
            end
        end else begin : g_next
            assign p_v   = r_v[s-1];
            assign p_rem = r_rem[s-1];
            assign p_lq  = r_lq[s-1];
            assign p_dvs = r_dvs[s-1];
            assign p_sb  = r_sb[s-1];
        end

        // low dividend bits shift out at the top while quotient bits enter below
        always_comb begin
            trial = '0;
            take  = 1'b0;
            for (int l = 0; l < LANES; l++) begin
                trial    = {p_rem[l], p_lq[l][Q_W-1]};
                take     = (trial >= {1'b0, p_dvs[l]});
                n_rem[l] = take ? D_W'(trial - {1'b0, p_dvs[l]}) : D_W'(trial);
                n_lq[l]  = {p_lq[l][Q_W-2:0], take};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem;
                r_lq[s]  <= n_lq;
                r_sb[s]  <= p_sb;
            end
        end

        if (s < Q_W - 1) begin : g_dreg
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_dvs[s] <= p_dvs;
                end
            end
        end
    end

    assign o_valid = r_v[Q_W-1];
    assign o_quot  = r_lq[Q_W-1];
    assign o_sb    = r_sb[Q_W-1];

endmodule

// File: src/pcimp_apply.sv
`timescale 1ns / 1ps

module pcimp_apply (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [2:0][30:0]       i_nm,
    input  logic [1:0][30:0]       i_k,
    input  pcimp_pkg::t_div_side   i_side,
    output logic                   o_valid,
    output logic [2:0][31:0]       o_new1,
    output logic [2:0][31:0]       o_new2,
    output pcimp_pkg::t_outcome    o_outcome
);

    typedef struct packed {
        logic [2:0][31:0] v1;
        logic [2:0][31:0] v2;
        logic [2:0]       pneg;
        logic             invalid;
        logic             sep;
        logic [2:0][30:0] nm;
        logic [1:0][30:0] k;
    } t_carry;

    t_carry     n_c0;
    t_carry     n_c4;
    t_carry     r_c1, r_c2, r_c3, r_c4, r_c5, r_c6, r_c7, r_c8;
    logic [8:0] r_valid;

    always_comb begin
        n_c0.v1      = i_side.v1;
        n_c0.v2      = i_side.v2;
        n_c0.pneg    = i_side.pneg;
        n_c0.invalid = i_side.invalid;
        n_c0.sep     = 1'b0;
        n_c0.nm      = i_nm;
        n_c0.k       = i_k;
    end

    logic signed [32:0] r_a1_rv   [3];
    logic signed [31:0] r_a1_ns   [3];
    logic signed [64:0] r_a2_prod [3];
    logic signed [66:0] r_a3_dot;
    logic [33:0]        r_a4_s;
    logic [64:0]        r_a5_p    [2];
    logic [34:0]        r_a6_g    [2];
    logic [65:0]        r_a7_q    [2][3];
    logic [35:0]        r_a8_d    [2][3];

    logic [66:0]        negdot_rnd;
    logic [65:0]        g_rnd     [2];
    logic [66:0]        d_rnd     [2][3];

    always_comb begin
        negdot_rnd = 67'(-r_a3_dot) + (67'd1 << (pcimp_pkg::NORM_BITS - 1));
        for (int j = 0; j < 2; j++) begin
            g_rnd[j] = 66'(r_a5_p[j]) + (66'd1 << (pcimp_pkg::NORM_BITS - 1));
            for (int i = 0; i < 3; i++) begin
                d_rnd[j][i] = 67'(r_a7_q[j][i]) + (67'd1 << (pcimp_pkg::NORM_BITS - 1));
            end
        end
    end

    always_comb begin
        n_c4     = r_c3;
        n_c4.sep = (r_a3_dot > 0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // relative velocity and signed normal
            for (int i = 0; i < 3; i++) begin
                r_a1_rv[i] <= $signed({n_c0.v1[i][31], n_c0.v1[i]})
                            - $signed({n_c0.v2[i][31], n_c0.v2[i]});
                r_a1_ns[i] <= n_c0.pneg[i] ? -$signed({1'b0, n_c0.nm[i]})
                                           : $signed({1'b0, n_c0.nm[i]});
            end
            r_c1 <= n_c0;
            for (int i = 0; i < 3; i++) begin
                r_a2_prod[i] <= r_a1_rv[i] * r_a1_ns[i];
            end
            r_c2 <= r_c1;
            r_a3_dot <= 67'(r_a2_prod[0]) + 67'(r_a2_prod[1]) + 67'(r_a2_prod[2]);
            r_c3 <= r_c2;
            // closing speed along the normal, back to velocity scale
            r_a4_s <= negdot_rnd[63:30];
            r_c4 <= n_c4;
            for (int j = 0; j < 2; j++) begin
                r_a5_p[j] <= 65'(r_a4_s) * 65'(r_c4.k[j]);
            end
            r_c5 <= r_c4;
            for (int j = 0; j < 2; j++) begin
                r_a6_g[j] <= g_rnd[j][64:30];
            end
            r_c6 <= r_c5;
            for (int j = 0; j < 2; j++) begin
                for (int i = 0; i < 3; i++) begin
                    r_a7_q[j][i] <= 66'(r_a6_g[j]) * 66'(r_c6.nm[i]);
                end
            end
            r_c7 <= r_c6;
            for (int j = 0; j < 2; j++) begin
                for (int i = 0; i < 3; i++) begin
                    r_a8_d[j][i] <= d_rnd[j][i][65:30];
                end
            end
            r_c8 <= r_c7;
        end
    end

    // final stage: apply, saturate, pick the outcome
    logic signed [37:0]  sum1 [3];
    logic signed [37:0]  sum2 [3];
    logic [2:0][31:0]    sat1, sat2;
    logic                clamped;
    logic [2:0][31:0]    n_new1, n_new2;
    pcimp_pkg::t_outcome n_outcome;

    always_comb begin
        clamped = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (r_c8.pneg[i]) begin
                sum1[i] = 38'(signed'(r_c8.v1[i])) - $signed({2'b00, r_a8_d[0][i]});
                sum2[i] = 38'(signed'(r_c8.v2[i])) + $signed({2'b00, r_a8_d[1][i]});
            end else begin
                sum1[i] = 38'(signed'(r_c8.v1[i])) + $signed({2'b00, r_a8_d[0][i]});
                sum2[i] = 38'(signed'(r_c8.v2[i])) - $signed({2'b00, r_a8_d[1][i]});
            end
            if (sum1[i][37:31] != {7{sum1[i][37]}}) begin
                clamped = 1'b1;
                sat1[i] = sum1[i][37] ? 32'h8000_0000 : 32'h7fff_ffff;
            end else begin
                sat1[i] = sum1[i][31:0];
            end
            if (sum2[i][37:31] != {7{sum2[i][37]}}) begin
                clamped = 1'b1;
                sat2[i] = sum2[i][37] ? 32'h8000_0000 : 32'h7fff_ffff;
            end else begin
                sat2[i] = sum2[i][31:0];
            end
        end
        if (r_c8.invalid) begin
            n_new1    = r_c8.v1;
            n_new2    = r_c8.v2;
            n_outcome = pcimp_pkg::OUT_INVALID;
        end else if (r_c8.sep) begin
            n_new1    = r_c8.v1;
            n_new2    = r_c8.v2;
            n_outcome = pcimp_pkg::OUT_SKIPPED;
        end else begin
            n_new1    = sat1;
            n_new2    = sat2;
            n_outcome = clamped ? pcimp_pkg::OUT_SATURATED : pcimp_pkg::OUT_APPLIED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_new1    <= n_new1;
            o_new2    <= n_new2;
            o_outcome <= n_outcome;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[7:0], i_valid};
        end
    end

    assign o_valid = r_valid[8];

endmodule

// File: src/particle_contact_impulse.sv
// Particle contact impulse resolver.
// i_item carries one contact: relative position (first minus second), both
// velocities and both masses. o_result returns both new velocities and an
// outcome code: applied, separating skipped, invalid input, or saturated.
// Both channels move an item when valid and ready are high on a clock edge.
// The restitution register is written through i_cfg_we / i_cfg_data; the user
// must write it only while the block is idle, as the block does not enforce it.
// Reset loads 1.0 and values above 1.0 act as 1.0. The pipeline has 4 prescale
// and square stages, 32 stages of the square root (two radicand bits each),
// 31 stages of the five-lane divider (one quotient bit each) and 9 impulse
// stages ending in the output register. One item is accepted in every cycle
// unless the receiver stalls with a result waiting; then the whole pipeline
// holds and i_item.ready drops; nothing is lost or repeated.
// A synchronous active-low reset empties the pipeline at once.
`timescale 1ns / 1ps
`include "particle_contact_impulse_defines.svh"

module particle_contact_impulse (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pcimp_pkg::RES_W-1:0]        i_cfg_data,
    pcimp_in_if.sink                           i_item,
    pcimp_out_if.source                        o_result
);

    localparam int unsigned SQ_SB_W  = $bits(pcimp_pkg::t_sqrt_side);
    localparam int unsigned DIV_SB_W = $bits(pcimp_pkg::t_div_side);
    localparam int unsigned DIV_N_W  = pcimp_pkg::DIV_D_W + pcimp_pkg::DIV_Q_W;

    logic [pcimp_pkg::RES_W-1:0] r_restitution;
    logic                        en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_restitution <= pcimp_pkg::RES_ONE;
        end else if (i_cfg_we) begin
            r_restitution <= i_cfg_data;
        end
    end

    logic                  apply_valid;
    assign en           = !apply_valid || o_result.ready;
    assign i_item.ready = en;

    logic                  prep_valid;
    logic [63:0]           prep_len2;
    pcimp_pkg::t_sqrt_side prep_side;

    pcimp_prep u_prep (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_valid       (i_item.valid),
        .i_pos         ({i_item.rel_pos_z, i_item.rel_pos_y, i_item.rel_pos_x}),
        .i_v1          ({i_item.first_vel_z, i_item.first_vel_y, i_item.first_vel_x}),
        .i_v2          ({i_item.second_vel_z, i_item.second_vel_y, i_item.second_vel_x}),
        .i_m1          (i_item.first_mass),
        .i_m2          (i_item.second_mass),
        .i_restitution (r_restitution),
        .o_valid       (prep_valid),
        .o_len2        (prep_len2),
        .o_side        (prep_side)
    );

    logic                  sqrt_valid;
    logic [31:0]           sqrt_root;
    logic [SQ_SB_W-1:0]    sqrt_sb;
    pcimp_pkg::t_sqrt_side sq_side;

    pcimp_sqrt #(
        .X_W  (pcimp_pkg::LEN2_W),
        .SB_W (SQ_SB_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (prep_valid),
        .i_x     (prep_len2),
        .i_sb    (prep_side),
        .o_valid (sqrt_valid),
        .o_root  (sqrt_root),
        .o_sb    (sqrt_sb)
    );

    assign sq_side = sqrt_sb;

    logic [pcimp_pkg::DIV_LANES-1:0][DIV_N_W-1:0]            div_dividend;
    logic [pcimp_pkg::DIV_LANES-1:0][pcimp_pkg::DIV_D_W-1:0] div_divisor;
    logic [pcimp_pkg::DIV_LANES-1:0][pcimp_pkg::DIV_Q_W-1:0] div_quot;
    pcimp_pkg::t_div_side                                    div_side_in;
    logic [DIV_SB_W-1:0]                                     div_sb;
    pcimp_pkg::t_div_side                                    div_side_out;
    logic                                                    div_valid;

    always_comb begin
        // lanes 0..2 give the unit normal, lanes 3..4 the mass shares
        for (int i = 0; i < 3; i++) begin
            div_dividend[i] = DIV_N_W'({sq_side.pm[i], 30'b0}) + DIV_N_W'(sqrt_root[31:1]);
            div_divisor[i]  = sqrt_root;
        end
        for (int j = 0; j < 2; j++) begin
            div_dividend[3+j] = DIV_N_W'(sq_side.kdiv[j]);
            div_divisor[3+j]  = pcimp_pkg::DIV_D_W'(sq_side.msum);
        end
        div_side_in.v1      = sq_side.v1;
        div_side_in.v2      = sq_side.v2;
        div_side_in.pneg    = sq_side.pneg;
        div_side_in.invalid = sq_side.invalid;
    end

    pcimp_div #(
        .LANES (pcimp_pkg::DIV_LANES),
        .D_W   (pcimp_pkg::DIV_D_W),
        .Q_W   (pcimp_pkg::DIV_Q_W),
        .SB_W  (DIV_SB_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (sqrt_valid),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .i_sb       (div_side_in),
        .o_valid    (div_valid),
        .o_quot     (div_quot),
        .o_sb       (div_sb)
    );

    assign div_side_out = div_sb;

    logic [2:0][31:0]    new1, new2;
    pcimp_pkg::t_outcome outcome;

    pcimp_apply u_apply (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (div_valid),
        .i_nm      (div_quot[2:0]),
        .i_k       (div_quot[4:3]),
        .i_side    (div_side_out),
        .o_valid   (apply_valid),
        .o_new1    (new1),
        .o_new2    (new2),
        .o_outcome (outcome)
    );

    assign o_result.valid            = apply_valid;
    assign o_result.new_first_vel_x  = new1[0];
    assign o_result.new_first_vel_y  = new1[1];
    assign o_result.new_first_vel_z  = new1[2];
    assign o_result.new_second_vel_x = new2[0];
    assign o_result.new_second_vel_y = new2[1];
    assign o_result.new_second_vel_z = new2[2];
    assign o_result.outcome          = outcome;

    // prescaled length always lands in the top two bits of the root
    `PCIMP_ASSERT_IMPLY(a_len_range, i_clk, i_rst_n,
        sqrt_valid && !sq_side.invalid, sqrt_root[31:30] != 2'b00)
    // normal components never exceed one
    `PCIMP_ASSERT_IMPLY(a_norm_range, i_clk, i_rst_n,
        div_valid && !div_side_out.invalid,
        (div_quot[0] <= 31'h4000_0000) && (div_quot[1] <= 31'h4000_0000)
        && (div_quot[2] <= 31'h4000_0000))
    // a stall freezes the inner stages
    `PCIMP_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n,
        !en, $stable(sqrt_valid) && $stable(div_valid) && $stable(sqrt_root))

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import pcimp_pkg::*;

    typedef struct {
        logic signed [31:0] pos [3];
        logic signed [31:0] va [3];
        logic signed [31:0] vb [3];
        logic [23:0]        ma;
        logic [23:0]        mb;
    } t_contact;

    typedef struct {
        logic signed [31:0] na [3];
        logic signed [31:0] nb [3];
        t_outcome           oc;
    } t_resolved;

    localparam int LATENCY   = 76;
    localparam int MAX_CYCLE = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [16:0] i_cfg_data = '0;

    pcimp_in_if  in_ch ();
    pcimp_out_if out_ch ();

    particle_contact_impulse DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_item     (in_ch.sink),
        .o_result   (out_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_contact  pending_q [$];
    t_resolved resolved_q [$];
    logic [16:0] restitution = RES_ONE;
    int  errors = 0;
    int  cycle = 0;
    int  in_idle_pct = 38;
    int  out_idle_pct = 38;
    int  hold_off = 0;
    bit  sent_cur = 0;

    function automatic logic [63:0] isqrt(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] half_up30(logic [63:0] x);
        return (x + (64'd1 << 29)) >> 30;
    endfunction

    function automatic logic signed [31:0] clamp32(longint v, inout bit hit);
        if (v > 64'sd2147483647) begin
            hit = 1;
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648) begin
            hit = 1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic t_resolved resolve_contact(t_contact c, logic [16:0] res);
        t_resolved r;
        logic [63:0] pm [3];
        logic [63:0] nm [3];
        bit neg [3];
        logic [63:0] mx, l2, len, e, s, f, msum, k1, k2, g1, g2;
        longint dot, d1, d2;
        bit hit;
        for (int i = 0; i < 3; i++) begin
            r.na[i] = c.va[i];
            r.nb[i] = c.vb[i];
            neg[i] = c.pos[i] < 0;
            pm[i] = neg[i] ? 64'(-longint'(c.pos[i])) : 64'(longint'(c.pos[i]));
        end
        if (c.ma == 0 || c.mb == 0 || (pm[0] | pm[1] | pm[2]) == 0) begin
            r.oc = OUT_INVALID;
            return r;
        end
        mx = pm[0];
        if (pm[1] > mx) mx = pm[1];
        if (pm[2] > mx) mx = pm[2];
        while (mx < (64'd1 << 30)) begin
            mx = mx << 1;
            for (int i = 0; i < 3; i++) pm[i] = pm[i] << 1;
        end
        l2 = pm[0] * pm[0] + pm[1] * pm[1] + pm[2] * pm[2];
        len = isqrt(l2);
        dot = 0;
        for (int i = 0; i < 3; i++) begin
            nm[i] = ((pm[i] << 30) + (len >> 1)) / len;
            dot += (longint'(c.va[i]) - longint'(c.vb[i]))
                   * (neg[i] ? -longint'(nm[i]) : longint'(nm[i]));
        end
        if (dot > 0) begin
            r.oc = OUT_SKIPPED;
            return r;
        end
        e = (res > RES_ONE) ? 64'(RES_ONE) : 64'(res);
        s = half_up30(64'(-dot));
        f = 64'd65536 + e;
        msum = 64'(c.ma) + 64'(c.mb);
        k1 = (((f * c.mb) << 14) + (msum >> 1)) / msum;
        k2 = (((f * c.ma) << 14) + (msum >> 1)) / msum;
        g1 = half_up30(s * k1);
        g2 = half_up30(s * k2);
        hit = 0;
        for (int i = 0; i < 3; i++) begin
            d1 = longint'(half_up30(g1 * nm[i]));
            d2 = longint'(half_up30(g2 * nm[i]));
            if (neg[i]) begin
                d1 = -d1;
                d2 = -d2;
            end
            r.na[i] = clamp32(longint'(c.va[i]) + d1, hit);
            r.nb[i] = clamp32(longint'(c.vb[i]) - d2, hit);
        end
        r.oc = hit ? OUT_SATURATED : OUT_APPLIED;
        return r;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 1) ? 32'($urandom_range(0, 300))
                                           : -32'($urandom_range(0, 300));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_vel();
        logic [31:0] w;
        w = $urandom;
        // mostly moderate speeds so impulses rarely saturate
        if ($urandom_range(0, 9) < 7) return 32'($signed(w) >>> $urandom_range(4, 14));
        return rand_word();
    endfunction

    function automatic logic [23:0] rand_mass();
        case ($urandom_range(0, 9))
            0: return 24'hffffff;
            1: return 24'd1;
            2: return 24'd0;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic t_contact rand_contact();
        t_contact c;
        for (int i = 0; i < 3; i++) begin
            c.pos[i] = rand_word();
            if ($urandom_range(0, 9) == 0) c.pos[i] = 0;
            c.va[i] = rand_vel();
            c.vb[i] = rand_vel();
        end
        if ($urandom_range(0, 49) == 0) c.pos = '{0, 0, 0};
        c.ma = rand_mass();
        c.mb = rand_mass();
        // favor approaching pairs so most items exercise the impulse path
        if ($urandom_range(0, 3) != 0) begin
            for (int i = 0; i < 3; i++) begin
                if ((c.va[i] > c.vb[i]) == (c.pos[i] > 0) && c.pos[i] != 0) begin
                    c.va[i] = c.vb[i];
                end
            end
        end
        return c;
    endfunction

    function automatic t_contact mk(int px, int py, int pz, int ax, int bx,
                                    logic [23:0] ma, logic [23:0] mb);
        t_contact c;
        c.pos = '{px, py, pz};
        c.va = '{ax, 0, 0};
        c.vb = '{bx, 0, 0};
        c.ma = ma;
        c.mb = mb;
        return c;
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (in_ch.valid && !sent_cur) begin
            // still offering
        end else if (pending_q.size() > 0 && $urandom_range(0, 99) >= in_idle_pct) begin
            in_ch.valid        <= 1'b1;
            in_ch.rel_pos_x    <= pending_q[0].pos[0];
            in_ch.rel_pos_y    <= pending_q[0].pos[1];
            in_ch.rel_pos_z    <= pending_q[0].pos[2];
            in_ch.first_vel_x  <= pending_q[0].va[0];
            in_ch.first_vel_y  <= pending_q[0].va[1];
            in_ch.first_vel_z  <= pending_q[0].va[2];
            in_ch.second_vel_x <= pending_q[0].vb[0];
            in_ch.second_vel_y <= pending_q[0].vb[1];
            in_ch.second_vel_z <= pending_q[0].vb[2];
            in_ch.first_mass   <= pending_q[0].ma;
            in_ch.second_mass  <= pending_q[0].mb;
            void'(pending_q.pop_front());
        end else begin
            in_ch.valid <= 1'b0;
        end
    end

    // receiver, with a counted hold-off
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            out_ch.ready <= 1'b0;
            hold_off <= hold_off - 1;
        end else begin
            out_ch.ready <= ($urandom_range(0, 99) >= out_idle_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_contact  c;
        t_resolved x;
        cycle <= cycle + 1;
        sent_cur <= i_rst_n && in_ch.valid && in_ch.ready;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            c.pos = '{in_ch.rel_pos_x, in_ch.rel_pos_y, in_ch.rel_pos_z};
            c.va = '{in_ch.first_vel_x, in_ch.first_vel_y, in_ch.first_vel_z};
            c.vb = '{in_ch.second_vel_x, in_ch.second_vel_y, in_ch.second_vel_z};
            c.ma = in_ch.first_mass;
            c.mb = in_ch.second_mass;
            resolved_q.push_back(resolve_contact(c, restitution));
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (resolved_q.size() == 0) begin
                $display("%0t: unexpected result item, outcome %0d", $time,
                         out_ch.outcome);
                errors <= errors + 1;
            end else begin
                x = resolved_q.pop_front();
                if (out_ch.new_first_vel_x !== x.na[0] || out_ch.new_first_vel_y !== x.na[1]
                    || out_ch.new_first_vel_z !== x.na[2]
                    || out_ch.new_second_vel_x !== x.nb[0]
                    || out_ch.new_second_vel_y !== x.nb[1]
                    || out_ch.new_second_vel_z !== x.nb[2] || out_ch.outcome !== x.oc) begin
                    $display("%0t: mismatch expected %0d %0d %0d / %0d %0d %0d oc %0d",
                             $time, x.na[0], x.na[1], x.na[2], x.nb[0], x.nb[1], x.nb[2],
                             x.oc);
                    $display("%0t:            actual %0d %0d %0d / %0d %0d %0d oc %0d",
                             $time, out_ch.new_first_vel_x, out_ch.new_first_vel_y,
                             out_ch.new_first_vel_z, out_ch.new_second_vel_x,
                             out_ch.new_second_vel_y, out_ch.new_second_vel_z,
                             out_ch.outcome);
                    errors <= errors + 1;
                end
            end
        end
        if (cycle >= MAX_CYCLE) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic drain();
        while (pending_q.size() > 0 || in_ch.valid || resolved_q.size() > 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_restitution(logic [16:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        restitution = val;
    endtask

    initial begin
        logic [16:0] settings [5];
        in_ch.valid = 1'b0;
        in_ch.rel_pos_x = 0;
        in_ch.rel_pos_y = 0;
        in_ch.rel_pos_z = 0;
        in_ch.first_vel_x = 0;
        in_ch.first_vel_y = 0;
        in_ch.first_vel_z = 0;
        in_ch.second_vel_x = 0;
        in_ch.second_vel_y = 0;
        in_ch.second_vel_z = 0;
        in_ch.first_mass = 0;
        in_ch.second_mass = 0;
        out_ch.ready = 1'b0;
        settings = '{17'd0, 17'd32768, 17'h1ffff, 17'd65535, RES_ONE};
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: invalid masses, coincident, separating, approaching, extremes
        pending_q.push_back(mk(65536, 0, 0, -65536, 0, 24'd0, 24'd65536));
        pending_q.push_back(mk(65536, 0, 0, -65536, 0, 24'd65536, 24'd0));
        pending_q.push_back(mk(0, 0, 0, -65536, 65536, 24'd65536, 24'd65536));
        pending_q.push_back(mk(65536, 0, 0, 65536, 0, 24'd65536, 24'd65536));
        pending_q.push_back(mk(65536, 0, 0, -65536, 65536, 24'd65536, 24'd65536));
        pending_q.push_back(mk(-65536, 3, 7, 65536, -65536, 24'd1, 24'hffffff));
        pending_q.push_back(mk(1, 1, 1, -100, 100, 24'hffffff, 24'hffffff));
        pending_q.push_back(mk(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                               32'h7fffffff, 24'hffffff, 24'd1));
        pending_q.push_back(mk(32'h80000000, 0, 0, 32'h7fffffff, 32'h80000000,
                               24'd1, 24'hffffff));
        pending_q.push_back(mk(0, 0, -1, 0, 0, 24'd100, 24'd100));
        pending_q.push_back(mk(3, -4, 0, 0, 0, 24'd5, 24'd7));
        drain();

        foreach (settings[k]) begin
            write_restitution(settings[k]);
            if (k == 2) begin
                // fill the pipeline against a long receiver stall
                in_idle_pct = 0;
                hold_off = 300;
            end
            if (k == 3) begin
                in_idle_pct = 0;
                out_idle_pct = 0;
            end
            for (int n = 0; n < 205; n++) pending_q.push_back(rand_contact());
            drain();
            in_idle_pct = 38;
            out_idle_pct = 38;
        end

        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
